// ===== rtl/hrsp_pkg.sv =====
package hrsp_pkg;

    // payload widths
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned DATA_W = 8;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // decoded hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    // ascii hex digit to nibble, ok low for anything else
    function automatic t_hex hex_decode(input logic [CHAR_W-1:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.nib = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.ok  = 1'b1;
            h.nib = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok  = 1'b1;
            h.nib = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

// ===== rtl/hrsp_in_if.sv =====
interface hrsp_in_if
    import hrsp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              stream_end;

    modport source (output valid, output character, output stream_end, input ready);
    modport sink   (input valid, input character, input stream_end, output ready);
endinterface

// ===== rtl/hrsp_out_if.sv =====
interface hrsp_out_if
    import hrsp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] data_byte;

    modport source (output valid, output result_kind, output byte_address,
                    output data_byte, input ready);
    modport sink   (input valid, input result_kind, input byte_address,
                    input data_byte, output ready);
endinterface

// ===== rtl/hex_record_stream_parser.sv =====
// Hex-record text parser.
// i_in carries one character of the record text per transaction, or a
// stream_end marker. o_out carries at most one result per input transaction:
// a data byte with its 32-bit address, an end-of-file mark or a format error.
// Each character is decoded in the cycle it is accepted; its result, if any,
// is valid on o_out on the next clock edge.
// Throughput is one character per cycle: i_in.ready is high whenever the
// output register is empty or is being taken in the same cycle, so the
// parser only waits while a result sits in o_out and the receiver stalls.
// The rate is set by the single state update loop over the parse state.
// After an end or error result the parser swallows every further character
// without producing results until reset.
// Reset (i_rst_n low at a clock edge) returns the parser to the start of a
// record with a zero high address and drops any pending result.
module hex_record_stream_parser
    import hrsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrsp_in_if.sink    i_in,
    hrsp_out_if.source o_out
);

    // parse phases
    localparam logic [2:0] PH_COLON    = 3'd0;
    localparam logic [2:0] PH_LENGTH   = 3'd1;
    localparam logic [2:0] PH_ADDRESS  = 3'd2;
    localparam logic [2:0] PH_TYPE     = 3'd3;
    localparam logic [2:0] PH_DATA     = 3'd4;
    localparam logic [2:0] PH_HIGH     = 3'd5;
    localparam logic [2:0] PH_CHECKSUM = 3'd6;
    localparam logic [2:0] PH_AFTER    = 3'd7;

    localparam logic [7:0]  CH_COLON   = 8'h3a;
    localparam logic [7:0]  CH_LF      = 8'h0a;
    localparam logic [15:0] TYPE_DATA  = 16'h0000;
    localparam logic [15:0] TYPE_EOF   = 16'h0001;
    localparam logic [15:0] TYPE_HIGH  = 16'h0004;

    logic [2:0]        r_phase, n_phase;
    logic [1:0]        r_cnt, n_cnt;
    logic [15:0]       r_acc, n_acc;
    logic [7:0]        r_len, n_len;
    logic [15:0]       r_low, n_low;
    logic [15:0]       r_high, n_high;
    logic [7:0]        r_off, n_off;
    logic              r_halted, n_halted;

    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;

    logic              w_in_fire;
    logic              w_emit;
    logic [KIND_W-1:0] w_kind;
    logic [ADDR_W-1:0] w_addr;
    logic [DATA_W-1:0] w_data;
    t_hex              w_hex;
    logic [15:0]       w_acc_sh;
    logic [2:0]        w_cnt_inc;
    logic [2:0]        w_need;
    logic              w_done;
    logic [7:0]        w_off_inc;

    // handshake
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_fire  = i_in.valid && i_in.ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.result_kind  = r_kind;
    assign o_out.byte_address = r_addr;
    assign o_out.data_byte    = r_data;

    // digit field helpers
    assign w_hex     = hex_decode(i_in.character);
    assign w_acc_sh  = {r_acc[11:0], w_hex.nib};
    assign w_cnt_inc = {1'b0, r_cnt} + 3'd1;
    assign w_need    = (r_phase == PH_ADDRESS || r_phase == PH_HIGH) ? 3'd4 : 3'd2;
    assign w_done    = (w_cnt_inc == w_need);
    assign w_off_inc = r_off + 8'd1;

    // next state and result for one character
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_len    = r_len;
        n_low    = r_low;
        n_high   = r_high;
        n_off    = r_off;
        n_halted = r_halted;
        w_emit   = 1'b0;
        w_kind   = KIND_DATA;
        w_addr   = '0;
        w_data   = '0;
        if (!r_halted) begin
            if (i_in.stream_end) begin
                w_emit   = 1'b1;
                w_kind   = KIND_ERROR;
                n_halted = 1'b1;
            end else begin
                unique case (r_phase) inside
                    PH_COLON, PH_AFTER: begin
                        if (r_phase == PH_AFTER && i_in.character == CH_LF) begin
                            n_phase = PH_COLON;
                        end else if (i_in.character != CH_COLON) begin
                            w_emit   = 1'b1;
                            w_kind   = KIND_ERROR;
                            n_halted = 1'b1;
                        end else begin
                            n_phase = PH_LENGTH;
                            n_cnt   = 2'd0;
                            n_acc   = 16'd0;
                        end
                    end
                    PH_LENGTH, PH_ADDRESS, PH_TYPE, PH_DATA, PH_HIGH, PH_CHECKSUM: begin
                        if (!w_hex.ok) begin
                            w_emit   = 1'b1;
                            w_kind   = KIND_ERROR;
                            n_halted = 1'b1;
                        end else if (!w_done) begin
                            n_acc = w_acc_sh;
                            n_cnt = w_cnt_inc[1:0];
                        end else begin
                            n_acc = 16'd0;
                            n_cnt = 2'd0;
                            unique case (r_phase)
                                PH_LENGTH: begin
                                    n_len = w_acc_sh[7:0];
                                    if (w_acc_sh[7:0] == 8'd0) begin
                                        w_emit   = 1'b1;
                                        w_kind   = KIND_END;
                                        n_halted = 1'b1;
                                    end else begin
                                        n_phase = PH_ADDRESS;
                                    end
                                end
                                PH_ADDRESS: begin
                                    n_low   = w_acc_sh;
                                    n_phase = PH_TYPE;
                                end
                                PH_TYPE: begin
                                    if (w_acc_sh == TYPE_DATA) begin
                                        n_off   = 8'd0;
                                        n_phase = PH_DATA;
                                    end else if (w_acc_sh == TYPE_HIGH) begin
                                        n_phase = PH_HIGH;
                                    end else if (w_acc_sh == TYPE_EOF) begin
                                        w_emit   = 1'b1;
                                        w_kind   = KIND_END;
                                        n_halted = 1'b1;
                                    end else begin
                                        w_emit   = 1'b1;
                                        w_kind   = KIND_ERROR;
                                        n_halted = 1'b1;
                                    end
                                end
                                PH_DATA: begin
                                    w_emit = 1'b1;
                                    w_kind = KIND_DATA;
                                    w_addr = {r_high, r_low} + {24'd0, r_off};
                                    w_data = w_acc_sh[7:0];
                                    n_off  = w_off_inc;
                                    if (w_off_inc == r_len) begin
                                        n_phase = PH_CHECKSUM;
                                    end
                                end
                                PH_HIGH: begin
                                    n_high  = w_acc_sh;
                                    n_phase = PH_CHECKSUM;
                                end
                                default: begin
                                    n_phase = PH_AFTER;
                                end
                            endcase
                        end
                    end
                    default: begin
                        w_emit   = 1'b1;
                        w_kind   = KIND_ERROR;
                        n_halted = 1'b1;
                    end
                endcase
            end
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_COLON;
            r_cnt    <= 2'd0;
            r_acc    <= 16'd0;
            r_len    <= 8'd0;
            r_low    <= 16'd0;
            r_high   <= 16'd0;
            r_off    <= 8'd0;
            r_halted <= 1'b0;
        end else if (w_in_fire) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_len    <= n_len;
            r_low    <= n_low;
            r_high   <= n_high;
            r_off    <= n_off;
            r_halted <= n_halted;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= w_emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_emit) begin
            r_kind <= w_kind;
            r_addr <= w_addr;
            r_data <= w_data;
        end
    end

`ifndef NO_ASSERTIONS
    // nothing new comes out once halted
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halted && w_in_fire) |=> !r_out_valid)
        else $error("result produced after halt");

    // end and error results always halt the parser
    a_stop_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_emit && w_kind != KIND_DATA) |=> r_halted)
        else $error("end or error did not halt");

    // data bytes only come from the payload field
    a_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_emit && w_kind == KIND_DATA) |-> (r_phase == PH_DATA))
        else $error("data byte outside payload");

    // end and error results carry zero address and byte
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != KIND_DATA) |-> (r_addr == '0 && r_data == '0))
        else $error("nonzero payload on end or error");
`endif

endmodule
